@@ design/assert_macros.svh @@
// Assertion macros used by the heap sort engine top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");
// Checks that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ design/hse_pkg.sv @@
// Package with shared constants of the heap sort engine.
`default_nettype none
package hse_pkg;
  localparam int DepthDefault   = 64;
  localparam int KeyBitsDefault = 32;
  localparam int TagBits        = 10;
  localparam int OutKeyBits     = 32;
endpackage
`default_nettype wire

@@ design/hse_store.sv @@
// Record memory of the heap sort engine: one write port, one registered read port.
`default_nettype none
module hse_store #(
  parameter int DEPTH    = hse_pkg::DepthDefault,
  parameter int KEY_BITS = hse_pkg::KeyBitsDefault,
  parameter int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [AW-1:0]                 waddr,
  input  wire logic [KEY_BITS+hse_pkg::TagBits-1:0] wdata,
  input  wire logic [AW-1:0]                 raddr,
  output logic      [KEY_BITS+hse_pkg::TagBits-1:0] rdata
);
  import hse_pkg::*;
  logic [KEY_BITS+TagBits-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ design/heap_sort_engine.sv @@
// Top level of the heap sort engine: loader, heap sequencer and output stage.
// Records are loaded at one per cycle while the input is ready. A record marked
// last starts an in-place heapsort over a record memory with one write port and
// one registered read port. Each level of a build sift-down reads both children
// and the parent and swaps parent and larger child if the child key is greater.
// In the select phase each record reads the last and root records and moves the
// root to the end; the descent then reads both children and writes the larger up
// per level, and the displaced record rises again, one parent read per level.
// The sorted records stream out one at a time, each read from the memory before
// it is presented; the next read waits until the previous record is taken. The
// input is not ready while a set is sorted or emitted. There is no clearing pass.
`default_nettype none
module heap_sort_engine #(
  parameter int DEPTH    = hse_pkg::DepthDefault,
  parameter int KEY_BITS = hse_pkg::KeyBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        valid,
  output logic             ready,
  input  wire logic [31:0] key,
  input  wire logic [hse_pkg::TagBits-1:0] tag,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      key_res,
  output logic [hse_pkg::TagBits-1:0] tag_res,
  output logic             last_res,
  output logic             overflow
);
  import hse_pkg::*;
  `include "assert_macros.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int RW = KEY_BITS + TagBits;

  typedef enum logic [3:0] {
    S_LOAD, S_BUILD_INIT, S_SIFT_RD1, S_SIFT_RD2, S_SIFT_CMP, S_SIFT_RDP,
    S_SIFT_SWAP, S_SEL_START, S_SEL_RD, S_SEL_MV, S_DOWN_RD1, S_DOWN_RD2,
    S_DOWN_CMP, S_UP_RD, S_UP_CMP, S_EMIT
  } state_t;

  state_t         state;
  logic [CW-1:0]  count;
  logic           dropped;
  logic [CW-1:0]  n;       // current heap size
  logic [CW-1:0]  start;
  logic [CW:0]    par;
  logic [CW:0]    child;
  logic [RW-1:0]  rec_a;   // first read record
  logic [RW-1:0]  rec_p;
  logic [RW-1:0]  held;
  logic [CW-1:0]  emit_idx;
  logic           emit_pend; // a read for emission is in flight
  logic           swap_tail;

  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [RW-1:0]  wdata, rdata;

  hse_store #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS), .AW(AW)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic [AW-1:0] pos2a(input logic [CW:0] p);
    logic [CW:0] t;
    t = p - 1'b1;
    return t[AW-1:0];
  endfunction

  function automatic logic [KEY_BITS-1:0] k_of(input logic [RW-1:0] r);
    return r[RW-1:TagBits];
  endfunction

  wire accept_in  = valid && ready;
  wire accept_out = out_valid && out_ready;
  wire [CW:0] n_w = {1'b0, n};

  assign ready = (state == S_LOAD);

  // Memory port control, combinational from state.
  always_comb begin
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    case (state)
      S_LOAD: begin
        we = accept_in && (count < CW'(DEPTH));
        waddr = count[AW-1:0];
        wdata = {KEY_BITS'(key), tag};
      end
      S_SIFT_RD1: begin
        raddr = pos2a(child);
        // The parent record displaced by the last swap lands one level down.
        if (swap_tail) begin
          we = 1'b1; waddr = pos2a(par); wdata = rec_p;
        end
      end
      S_DOWN_RD1: raddr = pos2a(child);
      S_SIFT_RD2, S_DOWN_RD2: raddr = pos2a(child + 1'b1);
      S_SIFT_RDP, S_UP_RD: raddr = pos2a(par);
      S_SIFT_SWAP: begin
        we = (k_of(rdata) < k_of(rec_a)); waddr = pos2a(par); wdata = rec_a;
      end
      S_SEL_START: raddr = pos2a(n_w);
      S_SEL_RD: raddr = '0;
      S_SEL_MV: begin
        we = 1'b1; waddr = pos2a(n_w); wdata = rdata;
      end
      S_DOWN_CMP: begin
        we = 1'b1; waddr = pos2a(par);
        wdata = (child < n_w && k_of(rec_a) < k_of(rdata)) ? rdata : rec_a;
      end
      S_UP_CMP: begin
        we = 1'b1; waddr = pos2a(child);
        wdata = (child == 1 || k_of(held) < k_of(rdata)) ? held : rdata;
      end
      S_EMIT: raddr = emit_idx[AW-1:0];
      default: ;
    endcase
  end

  logic [KEY_BITS-1:0] out_key_full;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD; count <= '0; dropped <= 1'b0; out_valid <= 1'b0;
      emit_pend <= 1'b0;
    end else begin
      case (state)
        S_LOAD: if (accept_in) begin
          if (count < CW'(DEPTH)) count <= count + 1'b1;
          else dropped <= 1'b1;
          if (last) begin
            n <= (count < CW'(DEPTH)) ? count + 1'b1 : count;
            start <= ((count < CW'(DEPTH)) ? count + 1'b1 : count) >> 1;
            state <= S_BUILD_INIT;
          end
        end
        S_BUILD_INIT: begin
          if (start == 0) begin
            state <= S_SEL_START;
          end else begin
            par <= {1'b0, start}; child <= {start, 1'b0};
            state <= S_SIFT_RD1;
          end
        end
        // Sift-down of the build phase; par/child positions.
        S_SIFT_RD1: begin
          if (child > n_w) begin
            start <= start - 1'b1; state <= S_BUILD_INIT;
          end else state <= S_SIFT_RD2;
        end
        S_SIFT_RD2: begin
          rec_a <= rdata;
          state <= S_SIFT_CMP;
        end
        S_SIFT_CMP: begin
          if (child < n_w && k_of(rec_a) < k_of(rdata)) begin
            rec_a <= rdata; child <= child + 1'b1;
          end
          state <= S_SIFT_RDP;
        end
        S_SIFT_RDP: state <= S_SIFT_SWAP;
        S_SIFT_SWAP: begin
          // Writes child record to parent now; parent record to child below.
          if (k_of(rec_a) <= k_of(rdata)) begin
            start <= start - 1'b1; state <= S_BUILD_INIT;
          end else begin
            rec_p <= rdata; state <= S_SIFT_RD1;
            par <= child; child <= child << 1;
          end
        end
        S_SEL_START: begin
          if (n <= 1) begin
            emit_idx <= '0; emit_pend <= 1'b0; state <= S_EMIT;
          end else state <= S_SEL_RD;
        end
        S_SEL_RD: begin
          held <= rdata; state <= S_SEL_MV;
        end
        S_SEL_MV: begin
          n <= n - 1'b1; par <= (CW+1)'(1); child <= (CW+1)'(2);
          state <= S_DOWN_RD1;
        end
        S_DOWN_RD1: begin
          if (child > n_w) begin
            child <= par; par <= par >> 1; state <= S_UP_RD;
          end else state <= S_DOWN_RD2;
        end
        S_DOWN_RD2: begin
          rec_a <= rdata; state <= S_DOWN_CMP;
        end
        S_DOWN_CMP: begin
          par <= (child < n_w && k_of(rec_a) < k_of(rdata)) ? child + 1'b1 : child;
          child <= ((child < n_w && k_of(rec_a) < k_of(rdata)) ? child + 1'b1 : child) << 1;
          state <= S_DOWN_RD1;
        end
        S_UP_RD: state <= S_UP_CMP;
        S_UP_CMP: begin
          if (child == 1 || k_of(held) < k_of(rdata)) state <= S_SEL_START;
          else begin
            child <= par; par <= par >> 1; state <= S_UP_RD;
          end
        end
        S_EMIT: begin
          if (accept_out) out_valid <= 1'b0;
          if (emit_pend) begin
            out_valid <= 1'b1;
            out_key_full <= k_of(rdata);
            tag_res <= rdata[TagBits-1:0];
            last_res <= (emit_idx == count);
            overflow <= dropped;
            emit_pend <= 1'b0;
          end else if (!out_valid || accept_out) begin
            if (emit_idx == count) begin
              if (!out_valid || accept_out) begin
                state <= S_LOAD; count <= '0; dropped <= 1'b0;
              end
            end else begin
              emit_idx <= emit_idx + 1'b1; emit_pend <= 1'b1;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // Marks the cycle after a build-phase swap, when the parent record still has
  // to be written to the child position.
  always_ff @(posedge clk) begin
    if (rst) swap_tail <= 1'b0;
    else swap_tail <= (state == S_SIFT_SWAP) && !(k_of(rec_a) <= k_of(rdata));
  end

  // Wider keys are cut to the output width, narrower ones are zero-extended.
  assign key_res = OutKeyBits'(out_key_full);

  `ASSERT_IMPL(a_no_in_busy, clk, rst, state != S_LOAD, !ready)
  `ASSERT_NEXT(a_count_cap, clk, rst, 1'b1, count <= CW'(DEPTH))
  `ASSERT_IMPL(a_out_emit, clk, rst, out_valid, state == S_EMIT)
endmodule
`default_nettype wire

@@ tb/tb_heap_sort_engine.sv @@
// Self-checking testbench of the heap sort engine: directed and random record sets.
`timescale 1ns / 100ps
`default_nettype none

class sorted_record_board;
  localparam int Cap = 64;
  logic [31:0] set_keys[Cap];
  logic [9:0]  set_tags[Cap];
  int          set_size;
  bit          set_dropped;
  logic [31:0] want_key[$];
  logic [9:0]  want_tag[$];
  bit          want_last[$];
  bit          want_ovf[$];
  int          errors;

  function new();
    set_size = 0;
    set_dropped = 0;
    errors = 0;
  endfunction

  // Heap positions run from 1; position p lives at entry p-1.
  function void heapsort_set(int n);
    int start, par, child;
    logic [31:0] hk, tk;
    logic [9:0]  ht, tt;
    if (n <= 1) return;
    for (start = n / 2; start >= 1; start--) begin
      par = start;
      while (par * 2 <= n) begin
        child = par * 2;
        if (child < n && set_keys[child-1] < set_keys[child]) child++;
        if (set_keys[child-1] <= set_keys[par-1]) break;
        tk = set_keys[par-1]; tt = set_tags[par-1];
        set_keys[par-1] = set_keys[child-1]; set_tags[par-1] = set_tags[child-1];
        set_keys[child-1] = tk; set_tags[child-1] = tt;
        par = child;
      end
    end
    while (n > 1) begin
      hk = set_keys[n-1]; ht = set_tags[n-1];
      set_keys[n-1] = set_keys[0]; set_tags[n-1] = set_tags[0];
      n--;
      par = 1;
      while (par * 2 <= n) begin
        child = par * 2;
        if (child < n && set_keys[child-1] < set_keys[child]) child++;
        set_keys[par-1] = set_keys[child-1]; set_tags[par-1] = set_tags[child-1];
        par = child;
      end
      // Sift the displaced record back up from the leaf reached.
      forever begin
        child = par;
        par = child / 2;
        if (child == 1 || hk < set_keys[par-1]) begin
          set_keys[child-1] = hk; set_tags[child-1] = ht;
          break;
        end
        set_keys[child-1] = set_keys[par-1]; set_tags[child-1] = set_tags[par-1];
      end
    end
  endfunction

  function void note_record(logic [31:0] k, logic [9:0] t, bit l);
    if (set_size < Cap) begin
      set_keys[set_size] = k;
      set_tags[set_size] = t;
      set_size++;
    end else begin
      set_dropped = 1;
    end
    if (!l) return;
    heapsort_set(set_size);
    for (int i = 0; i < set_size; i++) begin
      want_key.push_back(set_keys[i]);
      want_tag.push_back(set_tags[i]);
      want_last.push_back(i == set_size - 1);
      want_ovf.push_back(set_dropped);
    end
    set_size = 0;
    set_dropped = 0;
  endfunction

  function void check_record(logic [31:0] k, logic [9:0] t, logic l, logic o);
    logic [31:0] ek;
    logic [9:0]  et;
    bit el, eo;
    if (want_key.size() == 0) begin
      $error("result with nothing expected: key_res %h", k);
      errors++;
      return;
    end
    ek = want_key.pop_front();
    et = want_tag.pop_front();
    el = want_last.pop_front();
    eo = want_ovf.pop_front();
    if (k !== ek) begin $error("key_res expected %h got %h", ek, k); errors++; end
    if (t !== et) begin $error("tag_res expected %h got %h", et, t); errors++; end
    if (l !== el) begin $error("last_res expected %b got %b", el, l); errors++; end
    if (o !== eo) begin $error("overflow expected %b got %b", eo, o); errors++; end
  endfunction

  function int pending();
    return want_key.size();
  endfunction
endclass

module tb_heap_sort_engine;
  logic        clk;
  logic        rst;
  logic        valid;
  logic        ready;
  logic [31:0] key;
  logic [9:0]  tag;
  logic        last;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] key_res;
  logic [9:0]  tag_res;
  logic        last_res;
  logic        overflow;

  sorted_record_board board;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_off;
  longint cycles;
  localparam longint CycleLimit = 1000000;

  heap_sort_engine u_top (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready), .key(key), .tag(tag),
    .last(last), .out_valid(out_valid), .out_ready(out_ready), .key_res(key_res),
    .tag_res(tag_res), .last_res(last_res), .overflow(overflow)
  );

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  initial begin
    board = new();
    rst = 1'b1;
    valid = 1'b0;
    key = '0;
    tag = '0;
    last = 1'b0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 0;
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** heap_sort_engine: FAILED **");
      $finish;
    end
  end

  // Receiver: a long hold-off beats the random stall.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        board.check_record(key_res, tag_res, last_res, overflow);
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Valid stays high from one item to the next unless the sender idles.
  task automatic send_record(logic [31:0] k, logic [9:0] t, bit l);
    while ($urandom_range(99) < send_idle_pct) begin
      valid <= 1'b0;
      @(posedge clk);
    end
    valid <= 1'b1;
    key <= k;
    tag <= t;
    last <= l;
    do @(posedge clk); while (!ready);
    board.note_record(k, t, l);
  endtask

  task automatic wait_drained();
    valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key(int span);
    case ($urandom_range(3))
      0: return $urandom_range(span);
      1: return 32'hFFFF_FFFF - $urandom_range(span);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_set(int n, int span);
    for (int i = 0; i < n; i++)
      send_record(pick_key(span), 10'($urandom_range(1023)), i == n - 1);
  endtask

  initial begin
    int sent, n, span;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single record, field extremes, equal keys, ascending keys.
    send_record(32'hFFFF_FFFF, 10'h3FF, 1);
    send_record(32'h0, 10'h0, 0);
    send_record(32'hFFFF_FFFF, 10'h155, 0);
    send_record(32'h0, 10'h2AA, 0);
    send_record(32'h8000_0000, 10'h3FF, 1);
    for (int i = 0; i < 8; i++) send_record(32'd7, 10'(i), i == 7);
    for (int i = 0; i < 6; i++) send_record(32'(i), 10'h200 | 10'(i), i == 5);
    wait_drained();

    // Store full: more than capacity, last record dropped too.
    for (int i = 0; i < 70; i++) send_record($urandom_range(40), 10'(i), i == 69);
    wait_drained();

    sent = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      if (phase == 0) hold_off = 3000;
      for (int s = 0; s < 8; s++) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 8);
        span = ($urandom_range(1) == 0) ? 3 : 1000;
        send_set(n, span);
        sent += n;
        if (sent >= 330) break;
      end
      // The sender waits for the whole backlog to drain.
      wait_drained();
    end

    if (board.errors == 0 && board.pending() == 0)
      $display("** heap_sort_engine: PASSED **");
    else
      $display("** heap_sort_engine: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
